// File: src/hbrd_pkg.sv
// Package for the HID boot report decoder: event codes, key tables, decode record.
package hbrd_pkg;

  localparam int unsigned NumSlots = 6;
  localparam int unsigned NumCand  = 1 + 2 * NumSlots;
  localparam int unsigned TblLen   = 57;

  typedef enum logic [1:0] {
    EV_MODIFIER = 2'd0,
    EV_PRESS    = 2'd1,
    EV_RELEASE  = 2'd2,
    EV_MOVE     = 2'd3
  } event_kind_t;

  localparam logic [7:0] ShiftMask = 8'h22;
  localparam logic [7:0] CtrlMask  = 8'h11;

  localparam logic [7:0] KeyRight  = 8'h4F;
  localparam logic [7:0] KeyLeft   = 8'h50;
  localparam logic [7:0] KeyDown   = 8'h51;
  localparam logic [7:0] KeyUp     = 8'h52;
  localparam logic [7:0] AscRight  = 8'h83;
  localparam logic [7:0] AscLeft   = 8'h82;
  localparam logic [7:0] AscDown   = 8'h81;
  localparam logic [7:0] AscUp     = 8'h80;
  localparam logic [7:0] KeyRollover = 8'h01;

  localparam logic [7:0] PlainTbl [0:TblLen-1] = '{
    8'h00, 8'h00, 8'h00, 8'h00,
    8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69,
    8'h6a, 8'h6b, 8'h6c, 8'h6d, 8'h6e, 8'h6f, 8'h70, 8'h71, 8'h72,
    8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7a,
    8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
    8'h0d, 8'h1b, 8'h08, 8'h09, 8'h20, 8'h2d, 8'h3d, 8'h5b, 8'h5d, 8'h5c,
    8'h00, 8'h3b, 8'h27, 8'h60, 8'h2c, 8'h2e, 8'h2f
  };

  localparam logic [7:0] ShiftTbl [0:TblLen-1] = '{
    8'h00, 8'h00, 8'h00, 8'h00,
    8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49,
    8'h4a, 8'h4b, 8'h4c, 8'h4d, 8'h4e, 8'h4f, 8'h50, 8'h51, 8'h52,
    8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5a,
    8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e, 8'h26, 8'h2a, 8'h28, 8'h29,
    8'h0d, 8'h1b, 8'h08, 8'h09, 8'h20, 8'h5f, 8'h2b, 8'h7b, 8'h7d, 8'h7c,
    8'h00, 8'h3a, 8'h22, 8'h7e, 8'h3c, 8'h3e, 8'h3f
  };

  // Map a usage code to ASCII; arrows win over the tables.
  function automatic logic [7:0] translate(input logic [7:0] kc, input logic shift);
    logic [7:0] a;
    a = 8'h00;
    if (kc < 8'(TblLen)) begin
      a = shift ? ShiftTbl[kc[5:0]] : PlainTbl[kc[5:0]];
    end
    case (kc)
      KeyRight: a = AscRight;
      KeyLeft:  a = AscLeft;
      KeyDown:  a = AscDown;
      KeyUp:    a = AscUp;
      default:  ;
    endcase
    return a;
  endfunction

  // One decoded report: candidate event mask and everything the events carry.
  // Mask bit 0 is the modifier or move event, bits 1..6 presses, 7..12 releases.
  typedef struct packed {
    logic [NumCand-1:0]       mask;
    logic                     mouse;
    logic                     shift;
    logic                     ctrl;
    logic [NumSlots-1:0][7:0] press_key;
    logic [NumSlots-1:0][7:0] press_asc;
    logic [NumSlots-1:0][7:0] rel_key;
    logic [7:0]               dx;
    logic [8:0]               dy;
    logic [2:0]               btn;
  } decode_t;

endpackage

// File: src/hid_boot_report_decoder.sv
// Top level of the HID boot-protocol keyboard and mouse report decoder.
//
// in_*  : one 8-byte boot report per transfer, byte 0 in in_tdata[7:0].
// cfg_* : write channel for device_kind (0 keyboard, 1 mouse); always ready,
//         write only while no report is in flight.
// out_* : one event per transfer; tuser carries the event kind, tlast marks
//         the final event of a report.
// A keyboard report yields a modifier event, then presses of new translated
// keys, then releases of vanished keys (up to 13 events). A mouse report
// yields one move event, or none when idle.
// Each accepted report is held in the emitter, and its events leave through
// the output register. Throughput: one event per cycle from the single
// output register while the receiver is ready; the next report is taken
// in the cycle its predecessor issues its last event.
// Reset clears the previous report to zeros, device_kind to keyboard and
// drops any pending events. A stalled receiver holds the output register
// and the held report; input stays back-pressured until the run drains.
module hid_boot_report_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // report_b0 .. report_b7, 8 bits each from bit 0
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  output logic        out_tvalid,
  input  logic        out_tready,
  // shift_held, ctrl_held, key_code[7:0], ascii_code[7:0], move_dx[7:0],
  // move_dy[8:0], button_flags[2:0], zero pad [39:38]
  output logic [39:0] out_tdata,
  output logic [1:0]  out_tuser,  // event_kind
  output logic        out_tlast   // last_of_run
);

  logic              mouse_r;
  logic [7:0][7:0]   prev_r;
  logic [7:0][7:0]   rep;
  logic              accept;
  logic              free;
  hbrd_pkg::decode_t dec;

  assign rep       = in_tdata;
  assign in_tready = free;
  assign accept    = in_tvalid && free;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mouse_r <= 1'b0;
      prev_r  <= '0;
    end else begin
      if (cfg_valid) mouse_r <= cfg_data;
      if (accept) prev_r <= rep;
    end
  end

  hbrd_decode u_decode (
    .rep   (rep),
    .prev  (prev_r),
    .mouse (mouse_r),
    .dec   (dec)
  );

  hbrd_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .dec        (dec),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// File: src/hbrd_decode.sv
// Report decoder: compares a report with the previous one and builds the event mask.
module hbrd_decode (
  input  logic [7:0][7:0]   rep,
  input  logic [7:0][7:0]   prev,
  input  logic              mouse,
  output hbrd_pkg::decode_t dec
);

  logic                             sh;
  logic                             ct;
  logic [hbrd_pkg::NumSlots-1:0]    in_prev;
  logic [hbrd_pkg::NumSlots-1:0]    in_rep;
  logic [hbrd_pkg::NumSlots-1:0][7:0] asc;
  logic [8:0]                       dy;

  assign sh = (rep[0] & hbrd_pkg::ShiftMask) != 8'h00;
  assign ct = (rep[0] & hbrd_pkg::CtrlMask) != 8'h00;
  assign dy = 9'd0 - {rep[2][7], rep[2]};

  always_comb begin
    for (int i = 0; i < hbrd_pkg::NumSlots; i++) begin
      in_prev[i] = 1'b0;
      in_rep[i]  = 1'b0;
      for (int j = 0; j < hbrd_pkg::NumSlots; j++) begin
        if (rep[i+2] == prev[j+2]) in_prev[i] = 1'b1;
        if (prev[i+2] == rep[j+2]) in_rep[i]  = 1'b1;
      end
      asc[i] = hbrd_pkg::translate(rep[i+2], sh);
    end
  end

  always_comb begin
    dec = '0;
    dec.mouse = mouse;
    if (mouse) begin
      dec.dx  = rep[1];
      dec.dy  = dy;
      dec.btn = rep[0][2:0];
      dec.mask[0] = (rep[1] != 8'h00) || (rep[2] != 8'h00) ||
                    (rep[0][2:0] != prev[0][2:0]);
    end else begin
      dec.shift   = sh;
      dec.ctrl    = ct;
      dec.mask[0] = 1'b1;
      for (int i = 0; i < hbrd_pkg::NumSlots; i++) begin
        dec.press_key[i] = rep[i+2];
        dec.press_asc[i] = asc[i];
        dec.rel_key[i]   = prev[i+2];
        dec.mask[1+i] = (rep[i+2] != 8'h00) && (rep[i+2] != hbrd_pkg::KeyRollover) &&
                        !in_prev[i] && (asc[i] != 8'h00);
        dec.mask[1+hbrd_pkg::NumSlots+i] = (prev[i+2] != 8'h00) && !in_rep[i];
      end
    end
  end

endmodule

// File: src/hbrd_emit.sv
// Event emitter: holds one decoded report and sends its events one per cycle unless stalled.
module hbrd_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  hbrd_pkg::decode_t dec,
  output logic              free,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [39:0]       out_tdata,
  output logic [1:0]        out_tuser,
  output logic              out_tlast
);

  hbrd_pkg::decode_t st_r;
  logic [hbrd_pkg::NumCand-1:0] mask_r;
  logic [hbrd_pkg::NumCand-1:0] pick;
  logic [hbrd_pkg::NumCand-1:0] rest;
  logic [3:0]  idx;
  logic        issue;

  logic        out_v_r;
  logic [39:0] data_r;
  logic [39:0] data_nxt;
  logic [1:0]  kind_r;
  logic [1:0]  kind_nxt;
  logic        last_r;

  logic [7:0]  key;
  logic [7:0]  asc;

  assign pick  = mask_r & (~mask_r + 1'b1);
  assign rest  = mask_r & ~pick;
  assign issue = (mask_r != '0) && (!out_v_r || out_tready);
  assign free  = (mask_r == '0) || (issue && rest == '0);

  always_comb begin
    idx = 4'd0;
    for (int i = hbrd_pkg::NumCand - 1; i >= 0; i--) begin
      if (pick[i]) idx = 4'(i);
    end
  end

  always_comb begin
    key      = 8'h00;
    asc      = 8'h00;
    data_nxt = '0;
    if (idx == 4'd0) begin
      kind_nxt = st_r.mouse ? hbrd_pkg::EV_MOVE : hbrd_pkg::EV_MODIFIER;
    end else if (idx <= 4'(hbrd_pkg::NumSlots)) begin
      kind_nxt = hbrd_pkg::EV_PRESS;
      key      = st_r.press_key[3'(idx - 4'd1)];
      asc      = st_r.press_asc[3'(idx - 4'd1)];
    end else begin
      kind_nxt = hbrd_pkg::EV_RELEASE;
      key      = st_r.rel_key[3'(idx - 4'(hbrd_pkg::NumSlots + 1))];
    end
    data_nxt[0]     = st_r.shift;
    data_nxt[1]     = st_r.ctrl;
    data_nxt[9:2]   = key;
    data_nxt[17:10] = asc;
    data_nxt[25:18] = st_r.dx;
    data_nxt[34:26] = st_r.dy;
    data_nxt[37:35] = st_r.btn;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (load) begin
        mask_r <= dec.mask;
      end else if (issue) begin
        mask_r <= rest;
      end
      if (issue) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (load) st_r <= dec;
    if (issue) begin
      data_r <= data_nxt;
      kind_r <= kind_nxt;
      last_r <= (rest == '0);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = data_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

endmodule

// File: test/hid_boot_report_decoder_tb.sv
// Self-checking testbench for the HID boot report decoder: directed table, then random reports.
module hid_boot_report_decoder_tb;

  localparam int unsigned NUM_RANDOM  = 250;
  localparam int unsigned CFG_SETTLE  = 20;
  localparam logic [7:0]  SHIFT_BITS  = 8'h22;
  localparam logic [7:0]  CTRL_BITS   = 8'h11;
  localparam logic [7:0]  USAGE_RIGHT = 8'h4F;
  localparam logic [7:0]  USAGE_LEFT  = 8'h50;
  localparam logic [7:0]  USAGE_DOWN  = 8'h51;
  localparam logic [7:0]  USAGE_UP    = 8'h52;
  localparam logic        MODE_KBD    = 1'b0;
  localparam logic        MODE_MOUSE  = 1'b1;

  localparam logic [0:9][7:0] SHIFT_DIGITS = {
    8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e, 8'h26, 8'h2a, 8'h28, 8'h29
  };
  localparam logic [0:16][7:0] PUNCT_PLAIN = {
    8'h0d, 8'h1b, 8'h08, 8'h09, 8'h20, 8'h2d, 8'h3d, 8'h5b, 8'h5d,
    8'h5c, 8'h00, 8'h3b, 8'h27, 8'h60, 8'h2c, 8'h2e, 8'h2f
  };
  localparam logic [0:16][7:0] PUNCT_SHIFT = {
    8'h0d, 8'h1b, 8'h08, 8'h09, 8'h20, 8'h5f, 8'h2b, 8'h7b, 8'h7d,
    8'h7c, 8'h00, 8'h3a, 8'h22, 8'h7e, 8'h3c, 8'h3e, 8'h3f
  };

  typedef struct packed {
    hbrd_pkg::event_kind_t kind;
    logic        sh;
    logic        ct;
    logic [7:0]  kc;
    logic [7:0]  asc;
    logic [7:0]  dx;
    logic [8:0]  dy;
    logic [2:0]  btn;
    logic        tail;
  } key_event_t;

  typedef struct packed {
    logic        mouse;
    logic [63:0] rep;
    logic        typed;
    logic        none;
    key_event_t  ev;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  key_event_t  pending_events [$];
  dir_row_t    dir_table [$];
  logic [63:0] prev_rep;
  logic [63:0] last_sent;
  logic        mode_mouse;
  bit          calm;
  int          errors;
  int          stall_left;
  key_event_t  want_ev;

  hid_boot_report_decoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic key_event_t mk_ev(hbrd_pkg::event_kind_t k, logic s, logic c,
                                       logic [7:0] kc, logic [7:0] asc, logic [7:0] dx,
                                       logic [8:0] dy, logic [2:0] btn, logic tail);
    key_event_t e;
    e.kind = k;
    e.sh   = s;
    e.ct   = c;
    e.kc   = kc;
    e.asc  = asc;
    e.dx   = dx;
    e.dy   = dy;
    e.btn  = btn;
    e.tail = tail;
    return e;
  endfunction

  function automatic logic [63:0] kbd_report(logic [7:0] m, logic [7:0] k1, logic [7:0] k2,
                                             logic [7:0] k3, logic [7:0] k4, logic [7:0] k5,
                                             logic [7:0] k6);
    return {k6, k5, k4, k3, k2, k1, 8'h00, m};
  endfunction

  function automatic logic [63:0] mouse_report(logic [7:0] b, logic [7:0] dx, logic [7:0] dy);
    return {40'h0, dy, dx, b};
  endfunction

  function automatic logic [7:0] key_ascii(logic [7:0] kc, logic sh);
    logic [7:0] a;
    a = 8'h00;
    if (kc >= 8'd4 && kc <= 8'd29) begin
      a = (sh ? 8'h41 : 8'h61) + (kc - 8'd4);
    end else if (kc >= 8'd30 && kc <= 8'd39) begin
      if (sh) a = SHIFT_DIGITS[kc - 8'd30];
      else a = (kc == 8'd39) ? 8'h30 : 8'h31 + (kc - 8'd30);
    end else if (kc >= 8'd40 && kc <= 8'd56) begin
      a = sh ? PUNCT_SHIFT[kc - 8'd40] : PUNCT_PLAIN[kc - 8'd40];
    end
    // arrows ignore shift
    if (kc == USAGE_RIGHT) a = 8'h83;
    if (kc == USAGE_LEFT)  a = 8'h82;
    if (kc == USAGE_DOWN)  a = 8'h81;
    if (kc == USAGE_UP)    a = 8'h80;
    return a;
  endfunction

  function automatic bit slot_held(logic [63:0] r, logic [7:0] kc);
    for (int j = 2; j < 8; j++) begin
      if (r[8*j +: 8] == kc) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Compute the event run of one report and advance the stored report.
  function automatic void decode_report(logic [63:0] rep);
    key_event_t run_ev [13];
    key_event_t e;
    int         n;
    logic       sh;
    logic       ct;
    logic [7:0] kc;
    logic [7:0] a;
    logic [8:0] dy;
    n = 0;
    if (mode_mouse == MODE_KBD) begin
      sh = |(rep[7:0] & SHIFT_BITS);
      ct = |(rep[7:0] & CTRL_BITS);
      run_ev[n] = mk_ev(hbrd_pkg::EV_MODIFIER, sh, ct, 8'h00, 8'h00, 8'h00, 9'h000, 3'b000,
                        1'b0);
      n++;
      for (int i = 2; i < 8; i++) begin
        kc = rep[8*i +: 8];
        if (kc > 8'd1 && !slot_held(prev_rep, kc)) begin
          a = key_ascii(kc, sh);
          if (a != 8'h00) begin
            run_ev[n] = mk_ev(hbrd_pkg::EV_PRESS, sh, ct, kc, a, 8'h00, 9'h000, 3'b000, 1'b0);
            n++;
          end
        end
      end
      for (int i = 2; i < 8; i++) begin
        kc = prev_rep[8*i +: 8];
        if (kc != 8'h00 && !slot_held(rep, kc)) begin
          run_ev[n] = mk_ev(hbrd_pkg::EV_RELEASE, sh, ct, kc, 8'h00, 8'h00, 9'h000, 3'b000,
                            1'b0);
          n++;
        end
      end
    end else begin
      dy = -{rep[23], rep[23:16]};
      if (rep[15:8] != 8'h00 || rep[23:16] != 8'h00 || rep[2:0] != prev_rep[2:0]) begin
        run_ev[n] = mk_ev(hbrd_pkg::EV_MOVE, 1'b0, 1'b0, 8'h00, 8'h00, rep[15:8], dy,
                          rep[2:0], 1'b0);
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      e = run_ev[i];
      e.tail = (i == n - 1);
      pending_events.push_back(e);
    end
    prev_rep = rep;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] gen_keyboard();
    logic [63:0] rep;
    int          c;
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    rep = last_sent;
    rep[7:0]  = 8'($urandom);
    rep[15:8] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
    for (int i = 2; i < 8; i++) begin
      c = $urandom_range(0, 9);
      if (c == 5) rep[8*i +: 8] = 8'h00;
      else if (c >= 6 && c <= 8) rep[8*i +: 8] = 8'($urandom_range(4, 8'h52));
      else if (c == 9) begin
        case ($urandom_range(0, 3))
          0:       rep[8*i +: 8] = 8'h01;
          1:       rep[8*i +: 8] = 8'($urandom);
          2:       rep[8*i +: 8] = rep[23:16];
          default: rep[8*i +: 8] = 8'($urandom_range(8'h39, 8'h52));
        endcase
      end
      // otherwise hold the key from the last report
    end
    return rep;
  endfunction

  function automatic logic [7:0] gen_motion();
    if ($urandom_range(0, 4) == 0) return 8'($urandom);
    return 8'($urandom_range(0, 16) - 8);
  endfunction

  function automatic logic [63:0] gen_mouse();
    logic [63:0] rep;
    int          r;
    r = $urandom_range(0, 9);
    if (r == 0) return {$urandom, $urandom};
    rep = {$urandom, $urandom};
    if (r <= 2) begin
      rep[7:0]  = {5'($urandom), last_sent[2:0]};
      rep[23:8] = 16'h0000;
    end else if (r <= 4) begin
      rep[23:8] = 16'h0000;
    end else begin
      rep[15:8]  = gen_motion();
      rep[23:16] = gen_motion();
    end
    return rep;
  endfunction

  task automatic add_row(logic mouse, logic [63:0] rep, logic typed, logic none, key_event_t ev);
    dir_row_t row;
    row.mouse = mouse;
    row.rep   = rep;
    row.typed = typed;
    row.none  = none;
    row.ev    = ev;
    dir_table.push_back(row);
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_report(logic [63:0] rep, logic typed, logic none, key_event_t ev);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = rep;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    if (typed) begin
      if (!none) pending_events.push_back(ev);
      prev_rep = rep;
    end else begin
      decode_report(rep);
    end
    last_sent = rep;
    @(negedge clk);
  endtask

  task automatic write_mode(logic v);
    in_tvalid = 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    // idle mouse reports leave nothing to wait on, so let the pipe settle
    repeat (CFG_SETTLE) @(negedge clk);
    cfg_data  = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    mode_mouse = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic check_field(string name, logic [8:0] want, logic [8:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready = 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_tready = 1'b0;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
    end else begin
      out_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_events.size() == 0) begin
        $error("event transfer with nothing expected: kind %0d data %0h", out_tuser, out_tdata);
        errors++;
      end else begin
        want_ev = pending_events.pop_front();
        check_field("event_kind",   9'(want_ev.kind), 9'(out_tuser));
        check_field("shift_held",   9'(want_ev.sh),   9'(out_tdata[0]));
        check_field("ctrl_held",    9'(want_ev.ct),   9'(out_tdata[1]));
        check_field("key_code",     9'(want_ev.kc),   9'(out_tdata[9:2]));
        check_field("ascii_code",   9'(want_ev.asc),  9'(out_tdata[17:10]));
        check_field("move_dx",      9'(want_ev.dx),   9'(out_tdata[25:18]));
        check_field("move_dy",      want_ev.dy,       out_tdata[34:26]);
        check_field("button_flags", 9'(want_ev.btn),  9'(out_tdata[37:35]));
        check_field("last_of_run",  9'(want_ev.tail), 9'(out_tlast));
      end
    end
  end

  initial begin
    key_event_t no_ev;
    int         sent;
    int         phase;
    int         len;
    logic       v;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_valid  = 1'b0;
    cfg_data   = 1'b0;
    prev_rep   = '0;
    last_sent  = '0;
    mode_mouse = MODE_KBD;
    calm       = 1'b0;
    errors     = 0;
    stall_left = 0;
    no_ev      = '0;

    add_row(MODE_KBD, kbd_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1, 1'b0,
            mk_ev(hbrd_pkg::EV_MODIFIER, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 9'h000, 3'd0, 1'b1));
    add_row(MODE_KBD, 64'h0000_0000_0000_ffff, 1'b1, 1'b0,
            mk_ev(hbrd_pkg::EV_MODIFIER, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00, 9'h000, 3'd0, 1'b1));
    add_row(MODE_KBD, kbd_report(8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1, 1'b0,
            mk_ev(hbrd_pkg::EV_MODIFIER, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 9'h000, 3'd0, 1'b1));
    add_row(MODE_KBD, kbd_report(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1, 1'b0,
            mk_ev(hbrd_pkg::EV_MODIFIER, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00, 9'h000, 3'd0, 1'b1));
    add_row(MODE_KBD, kbd_report(8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09), 1'b0, 1'b0,
            no_ev);
    // same keys held, only shift changes
    add_row(MODE_KBD, kbd_report(8'h02, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09), 1'b1, 1'b0,
            mk_ev(hbrd_pkg::EV_MODIFIER, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 9'h000, 3'd0, 1'b1));
    add_row(MODE_KBD, kbd_report(8'h20, 8'h4f, 8'h50, 8'h51, 8'h52, 8'h01, 8'h00), 1'b0, 1'b0,
            no_ev);
    add_row(MODE_KBD, kbd_report(8'h00, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01), 1'b0, 1'b0,
            no_ev);
    add_row(MODE_KBD, kbd_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0, 1'b0,
            no_ev);
    add_row(MODE_KBD, kbd_report(8'h20, 8'h1e, 8'h1e, 8'h2d, 8'h38, 8'hff, 8'h32), 1'b0, 1'b0,
            no_ev);
    add_row(MODE_KBD, kbd_report(8'h10, 8'h39, 8'h80, 8'he0, 8'h00, 8'h00, 8'h00), 1'b0, 1'b0,
            no_ev);
    add_row(MODE_KBD, kbd_report(8'h00, 8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h35), 1'b0, 1'b0,
            no_ev);
    // six presses and six releases in one run
    add_row(MODE_KBD, kbd_report(8'h40, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09), 1'b0, 1'b0,
            no_ev);
    add_row(MODE_KBD, kbd_report(8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0, 1'b0,
            no_ev);
    // mouse mode inherits the stored keyboard report, buttons read as 7
    add_row(MODE_MOUSE, mouse_report(8'h00, 8'h00, 8'h00), 1'b1, 1'b0,
            mk_ev(hbrd_pkg::EV_MOVE, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 9'h000, 3'd0, 1'b1));
    add_row(MODE_MOUSE, mouse_report(8'h00, 8'h00, 8'h00), 1'b1, 1'b1, no_ev);
    add_row(MODE_MOUSE, mouse_report(8'h00, 8'h7f, 8'h80), 1'b1, 1'b0,
            mk_ev(hbrd_pkg::EV_MOVE, 1'b0, 1'b0, 8'h00, 8'h00, 8'h7f, 9'h080, 3'd0, 1'b1));
    add_row(MODE_MOUSE, mouse_report(8'h07, 8'h80, 8'h7f), 1'b1, 1'b0,
            mk_ev(hbrd_pkg::EV_MOVE, 1'b0, 1'b0, 8'h00, 8'h00, 8'h80, 9'h181, 3'd7, 1'b1));
    add_row(MODE_MOUSE, 64'hffff_ffff_ff00_00f8, 1'b1, 1'b0,
            mk_ev(hbrd_pkg::EV_MOVE, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 9'h000, 3'd0, 1'b1));
    add_row(MODE_MOUSE, 64'h5aa5_c33c_9600_00f8, 1'b1, 1'b1, no_ev);
    add_row(MODE_MOUSE, mouse_report(8'h00, 8'h00, 8'h01), 1'b1, 1'b0,
            mk_ev(hbrd_pkg::EV_MOVE, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 9'h1ff, 3'd0, 1'b1));
    // back to keyboard: the stored dy byte 0x01 now counts as a held rollover key
    add_row(MODE_KBD, kbd_report(8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0, 1'b0,
            no_ev);
    add_row(MODE_KBD, kbd_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0, 1'b0,
            no_ev);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_mode(MODE_KBD);
    foreach (dir_table[i]) begin
      if (dir_table[i].mouse != mode_mouse) write_mode(dir_table[i].mouse);
      send_report(dir_table[i].rep, dir_table[i].typed, dir_table[i].none, dir_table[i].ev);
    end

    sent  = 0;
    phase = 0;
    while (sent < NUM_RANDOM) begin
      v = (phase < 2) ? ~mode_mouse : 1'($urandom_range(0, 1));
      write_mode(v);
      calm = (phase % 4 == 3);
      len  = $urandom_range(15, 45);
      for (int k = 0; k < len && sent < NUM_RANDOM; k++) begin
        send_report((mode_mouse == MODE_MOUSE) ? gen_mouse() : gen_keyboard(), 1'b0, 1'b0,
                    no_ev);
        sent++;
      end
      calm = 1'b0;
      phase++;
    end

    in_tvalid = 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
